### design/jse_pkg.sv
// jse_pkg: shared constants, types and helpers for the JSON string escaper.
// Holds the job descriptor passed from front end to back end through the queue.
// No dependencies.
package jse_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_N       = 8'h6e;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_U       = 8'h75;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] ASCII_LIMIT = 8'h80;

	localparam logic [7:0] REPL_B0 = 8'hef;
	localparam logic [7:0] REPL_B1 = 8'hbf;
	localparam logic [7:0] REPL_B2 = 8'hbd;

	localparam logic [7:0] LEAD_MIN  = 8'hc2;
	localparam logic [7:0] LEAD2_MAX = 8'hdf;
	localparam logic [7:0] LEAD3_MAX = 8'hef;
	localparam logic [7:0] LEAD4_MAX = 8'hf4;
	localparam logic [7:0] CONT_LO   = 8'h80;
	localparam logic [7:0] CONT_HI   = 8'hbf;
	localparam logic [7:0] LEAD_E0   = 8'he0;
	localparam logic [7:0] LEAD_ED   = 8'hed;
	localparam logic [7:0] LEAD_F0   = 8'hf0;
	localparam logic [7:0] LEAD_F4   = 8'hf4;
	localparam logic [7:0] E0_LO     = 8'ha0;
	localparam logic [7:0] ED_HI     = 8'h9f;
	localparam logic [7:0] F0_LO     = 8'h90;
	localparam logic [7:0] F4_HI     = 8'h8f;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PAIR,
		ESC_UNI
	} esc_kind_t;

	// Output order: opening quote, replacements, passed bytes, escape, closing quote.
	typedef struct packed {
		logic            open_quote;
		logic [2:0]      repl_n;
		logic [2:0]      pass_n;
		logic [3:0][7:0] pass_bytes;
		esc_kind_t       esc_kind;
		logic [7:0]      esc_char;
		logic            close_quote;
	} job_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = CH_ZERO + {4'h0, n};
		end else begin
			r = 8'h57 + {4'h0, n};
		end
		return r;
	endfunction

	// Is c acceptable as continuation number pos (1..3) after lead?
	function automatic logic fits(input logic [7:0] lead, input logic [1:0] pos,
		input logic [7:0] c);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_LO;
		hi = CONT_HI;
		if (pos == 2'd1) begin
			if (lead == LEAD_E0) begin
				lo = E0_LO;
			end else if (lead == LEAD_ED) begin
				hi = ED_HI;
			end else if (lead == LEAD_F0) begin
				lo = F0_LO;
			end else if (lead == LEAD_F4) begin
				hi = F4_HI;
			end
		end
		return (c >= lo) && (c <= hi);
	endfunction

endpackage

### design/jse_front.sv
// jse_front: accepts input beats, tracks string and UTF-8 hold state,
// and turns each beat into a job descriptor. Depends on jse_pkg.
module jse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              string_end,
	input  logic              full,
	output logic              push,
	output jse_pkg::job_t     push_job
);

	logic            open_q;
	logic [1:0]      held_cnt_q;
	logic [2:0]      seq_len_q;
	logic [2:0][7:0] held_q;

	logic            accept;
	logic            nxt_open;
	logic [1:0]      nxt_cnt;
	logic [2:0]      nxt_seq;
	logic            hold_we;
	logic [1:0]      hold_idx;
	logic            do_fresh;
	logic            job_empty;
	jse_pkg::job_t   job;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		job             = '0;
		job.esc_kind    = jse_pkg::ESC_NONE;
		job.pass_bytes  = {4{data_byte}};
		job.open_quote  = !open_q;
		nxt_open        = 1'b1;
		nxt_cnt         = held_cnt_q;
		nxt_seq         = seq_len_q;
		hold_we         = 1'b0;
		hold_idx        = 2'd0;
		do_fresh        = 1'b0;

		if (string_end) begin
			job.repl_n      = {1'b0, held_cnt_q};
			job.close_quote = 1'b1;
			nxt_open        = 1'b0;
			nxt_cnt         = 2'd0;
			nxt_seq         = 3'd0;
		end else if (held_cnt_q != 2'd0 && seq_len_q >= 3'd2) begin
			if (jse_pkg::fits(held_q[0], held_cnt_q, data_byte)) begin
				if ({1'b0, held_cnt_q} + 3'd1 >= seq_len_q) begin
					job.pass_n = {1'b0, held_cnt_q} + 3'd1;
					for (int i = 0; i < 3; i++) begin
						job.pass_bytes[i] = (2'(i) < held_cnt_q) ? held_q[i] : data_byte;
					end
					job.pass_bytes[3] = data_byte;
					nxt_cnt = 2'd0;
					nxt_seq = 3'd0;
				end else begin
					hold_we  = 1'b1;
					hold_idx = held_cnt_q;
					nxt_cnt  = held_cnt_q + 2'd1;
				end
			end else begin
				job.repl_n = {1'b0, held_cnt_q};
				nxt_cnt    = 2'd0;
				nxt_seq    = 3'd0;
				do_fresh   = 1'b1;
			end
		end else begin
			nxt_cnt  = 2'd0;
			nxt_seq  = 3'd0;
			do_fresh = 1'b1;
		end

		if (do_fresh) begin
			priority if (data_byte == jse_pkg::CH_QUOTE || data_byte == jse_pkg::CH_BSLASH) begin
				job.esc_kind = jse_pkg::ESC_PAIR;
				job.esc_char = data_byte;
			end else if (data_byte == jse_pkg::CH_LF) begin
				job.esc_kind = jse_pkg::ESC_PAIR;
				job.esc_char = jse_pkg::CH_N;
			end else if (data_byte == jse_pkg::CH_CR) begin
				job.esc_kind = jse_pkg::ESC_PAIR;
				job.esc_char = jse_pkg::CH_R;
			end else if (data_byte == jse_pkg::CH_TAB) begin
				job.esc_kind = jse_pkg::ESC_PAIR;
				job.esc_char = jse_pkg::CH_T;
			end else if (data_byte < jse_pkg::CTRL_LIMIT) begin
				job.esc_kind = jse_pkg::ESC_UNI;
				job.esc_char = data_byte;
			end else if (data_byte < jse_pkg::ASCII_LIMIT) begin
				job.pass_n = 3'd1;
			end else if (data_byte >= jse_pkg::LEAD_MIN && data_byte <= jse_pkg::LEAD4_MAX) begin
				hold_we  = 1'b1;
				hold_idx = 2'd0;
				nxt_cnt  = 2'd1;
				if (data_byte <= jse_pkg::LEAD2_MAX) begin
					nxt_seq = 3'd2;
				end else if (data_byte <= jse_pkg::LEAD3_MAX) begin
					nxt_seq = 3'd3;
				end else begin
					nxt_seq = 3'd4;
				end
			end else begin
				job.repl_n = job.repl_n + 3'd1;
			end
		end
	end

	assign job_empty = !job.open_quote && !job.close_quote && job.repl_n == 3'd0 &&
		job.pass_n == 3'd0 && job.esc_kind == jse_pkg::ESC_NONE;
	assign push      = accept && !job_empty;
	assign push_job  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			held_cnt_q <= 2'd0;
			seq_len_q  <= 3'd0;
		end else if (accept) begin
			open_q     <= nxt_open;
			held_cnt_q <= nxt_cnt;
			seq_len_q  <= nxt_seq;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_we) begin
			held_q[hold_idx] <= data_byte;
		end
	end

	a_held_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != 2'd0 |-> (seq_len_q >= 3'd2 && {1'b0, held_cnt_q} < seq_len_q))
		else $error("held count out of step with sequence length");

endmodule

### design/jse_fifo.sv
// jse_fifo: short job queue between front end and back end.
// Depends on jse_pkg for the job descriptor type.
module jse_fifo #(
	parameter int unsigned DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jse_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output jse_pkg::job_t pop_job,
	output logic          empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	jse_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue read while empty");

endmodule

### design/jse_back.sv
// jse_back: takes jobs from the queue and emits their bytes, one per beat.
// The job register doubles as the output register. Depends on jse_pkg.
module jse_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  jse_pkg::job_t pop_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          closing_quote
);

	logic            open_q;
	logic [2:0]      repl_q;
	logic [1:0]      rph_q;
	logic [2:0]      pass_cnt_q;
	logic [3:0][7:0] pass_q;
	logic [2:0]      esc_cnt_q;
	jse_pkg::esc_kind_t esc_kind_q;
	logic [7:0]      esc_char_q;
	logic            close_q;

	logic            fire;
	logic            rest;
	logic [7:0]      esc_byte;

	assign out_valid = open_q || repl_q != 3'd0 || pass_cnt_q != 3'd0 ||
		esc_cnt_q != 3'd0 || close_q;
	assign fire = out_valid && out_ready;
	assign pop  = !empty && (!out_valid || (fire && run_last));

	always_comb begin
		if (esc_kind_q == jse_pkg::ESC_PAIR) begin
			esc_byte = (esc_cnt_q == 3'd2) ? jse_pkg::CH_BSLASH : esc_char_q;
		end else begin
			unique case (esc_cnt_q)
				3'd5:    esc_byte = jse_pkg::CH_U;
				3'd4:    esc_byte = jse_pkg::CH_ZERO;
				3'd3:    esc_byte = jse_pkg::CH_ZERO;
				3'd2:    esc_byte = jse_pkg::hex_char(esc_char_q[7:4]);
				3'd1:    esc_byte = jse_pkg::hex_char(esc_char_q[3:0]);
				default: esc_byte = jse_pkg::CH_BSLASH;
			endcase
		end
	end

	always_comb begin
		closing_quote = 1'b0;
		priority if (open_q) begin
			out_byte = jse_pkg::CH_QUOTE;
			rest = repl_q != 3'd0 || pass_cnt_q != 3'd0 || esc_cnt_q != 3'd0 || close_q;
		end else if (repl_q != 3'd0) begin
			unique case (rph_q)
				2'd0:    out_byte = jse_pkg::REPL_B0;
				2'd1:    out_byte = jse_pkg::REPL_B1;
				default: out_byte = jse_pkg::REPL_B2;
			endcase
			rest = repl_q > 3'd1 || rph_q != 2'd2 || pass_cnt_q != 3'd0 ||
				esc_cnt_q != 3'd0 || close_q;
		end else if (pass_cnt_q != 3'd0) begin
			out_byte = pass_q[0];
			rest = pass_cnt_q > 3'd1 || esc_cnt_q != 3'd0 || close_q;
		end else if (esc_cnt_q != 3'd0) begin
			out_byte = esc_byte;
			rest = esc_cnt_q > 3'd1 || close_q;
		end else begin
			out_byte      = jse_pkg::CH_QUOTE;
			closing_quote = close_q;
			rest          = 1'b0;
		end
	end

	assign run_last = !rest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			repl_q     <= 3'd0;
			rph_q      <= 2'd0;
			pass_cnt_q <= 3'd0;
			esc_cnt_q  <= 3'd0;
			close_q    <= 1'b0;
		end else if (pop) begin
			open_q     <= pop_job.open_quote;
			repl_q     <= pop_job.repl_n;
			rph_q      <= 2'd0;
			pass_cnt_q <= pop_job.pass_n;
			unique case (pop_job.esc_kind)
				jse_pkg::ESC_PAIR: esc_cnt_q <= 3'd2;
				jse_pkg::ESC_UNI:  esc_cnt_q <= 3'd6;
				default:           esc_cnt_q <= 3'd0;
			endcase
			close_q    <= pop_job.close_quote;
		end else if (fire) begin
			priority if (open_q) begin
				open_q <= 1'b0;
			end else if (repl_q != 3'd0) begin
				if (rph_q == 2'd2) begin
					rph_q  <= 2'd0;
					repl_q <= repl_q - 3'd1;
				end else begin
					rph_q <= rph_q + 2'd1;
				end
			end else if (pass_cnt_q != 3'd0) begin
				pass_cnt_q <= pass_cnt_q - 3'd1;
			end else if (esc_cnt_q != 3'd0) begin
				esc_cnt_q <= esc_cnt_q - 3'd1;
			end else begin
				close_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pass_q     <= pop_job.pass_bytes;
			esc_kind_q <= pop_job.esc_kind;
			esc_char_q <= pop_job.esc_char;
		end else if (fire && !open_q && repl_q == 3'd0 && pass_cnt_q != 3'd0) begin
			pass_q <= {8'h00, pass_q[3:1]};
		end
	end

	a_job_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("loaded job produced no beat");

	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		closing_quote |-> (out_valid && run_last))
		else $error("closing quote not last beat of its job");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && run_last && empty) |=> !out_valid)
		else $error("output still valid after last job drained");

endmodule

### design/json_string_escaper_utf8_sanitize_top.sv
// Top level of the JSON string escaper with strict UTF-8 sanitizing.
// Instantiates jse_front, jse_fifo and jse_back; depends on jse_pkg.
//
// Input channel (in_valid/in_ready): one raw byte per beat in data_byte, or a
// beat with string_end set that flushes held bytes and closes the string.
// Output channel (out_valid/out_ready): one byte of quoted, escaped JSON text
// per beat; run_last marks the last byte caused by an input beat and
// closing_quote marks the closing quote.
// The accepting edge writes a beat's job into the job queue; the back end later
// pops it into the output register, which then drives its first output byte.
// Throughput: one input beat per cycle while the job queue has room; one
// output byte per cycle while the receiver is ready. A beat expands to 0..15
// bytes, so the sustained input rate is set by the output side, with the
// QUEUE_DEPTH-entry job queue absorbing bursts.
// A stalled receiver holds the current byte steady; the front end keeps taking
// beats until the queue fills, then drops in_ready.
// Reset empties the queue and the output register and forgets any open string
// or held UTF-8 bytes; the next beat starts a new string with its quote.
module json_string_escaper_utf8_sanitize_top #(
	parameter int unsigned QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       string_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       closing_quote
);

	logic          push;
	logic          full;
	logic          pop;
	logic          empty;
	jse_pkg::job_t push_job;
	jse_pkg::job_t pop_job;

	jse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.string_end (string_end),
		.full       (full),
		.push       (push),
		.push_job   (push_job)
	);

	jse_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	jse_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.pop_job       (pop_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.run_last      (run_last),
		.closing_quote (closing_quote)
	);

endmodule

### verif/jse_text_checker.sv
// jse_text_checker: watches both channels of the JSON string escaper, predicts the
// escaped text from each accepted input beat and compares every output beat.
// Depends on jse_pkg for the character constants.
module jse_text_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       string_end,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	input  logic       closing_quote,
	output int         mismatches,
	output int         pending
);

	typedef struct {
		logic [7:0] value;
		logic       last;
		logic       close;
	} text_byte_t;

	text_byte_t expected_text[$];

	logic       str_open;
	logic [1:0] held_n;
	logic [7:0] held[3];
	logic [2:0] seq_len;
	int         beat_bytes;

	initial mismatches = 0;

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	// 15 bytes at most per beat
	task automatic emit_byte(input logic [7:0] v, input logic close);
		text_byte_t t;
		t.value = v;
		t.last = 1'b0;
		t.close = close;
		if (beat_bytes < 15) begin
			expected_text.push_back(t);
			beat_bytes++;
		end
	endtask

	task automatic emit_replacement();
		emit_byte(jse_pkg::REPL_B0, 1'b0);
		emit_byte(jse_pkg::REPL_B1, 1'b0);
		emit_byte(jse_pkg::REPL_B2, 1'b0);
	endtask

	task automatic flush_held();
		for (int i = 0; i < int'(held_n); i++) emit_replacement();
		held_n = 2'd0;
		seq_len = 3'd0;
	endtask

	function automatic logic [7:0] hex_digit(input logic [3:0] d);
		return (d < 4'd10) ? 8'h30 + 8'(d) : 8'h61 + 8'(d) - 8'd10;
	endfunction

	function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
		input logic [7:0] c);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hbf;
		if (pos == 2'd1) begin
			unique case (lead)
				jse_pkg::LEAD_E0: lo = 8'ha0;
				jse_pkg::LEAD_ED: hi = 8'h9f;
				jse_pkg::LEAD_F0: lo = 8'h90;
				jse_pkg::LEAD_F4: hi = 8'h8f;
				default: ;
			endcase
		end
		return c >= lo && c <= hi;
	endfunction

	task automatic escape_fresh(input logic [7:0] c);
		if (c == jse_pkg::CH_QUOTE || c == jse_pkg::CH_BSLASH) begin
			emit_byte(jse_pkg::CH_BSLASH, 1'b0);
			emit_byte(c, 1'b0);
		end else if (c == jse_pkg::CH_LF) begin
			emit_byte(jse_pkg::CH_BSLASH, 1'b0);
			emit_byte(jse_pkg::CH_N, 1'b0);
		end else if (c == jse_pkg::CH_CR) begin
			emit_byte(jse_pkg::CH_BSLASH, 1'b0);
			emit_byte(jse_pkg::CH_R, 1'b0);
		end else if (c == jse_pkg::CH_TAB) begin
			emit_byte(jse_pkg::CH_BSLASH, 1'b0);
			emit_byte(jse_pkg::CH_T, 1'b0);
		end else if (c < 8'h20) begin
			emit_byte(jse_pkg::CH_BSLASH, 1'b0);
			emit_byte(jse_pkg::CH_U, 1'b0);
			emit_byte(jse_pkg::CH_ZERO, 1'b0);
			emit_byte(jse_pkg::CH_ZERO, 1'b0);
			emit_byte(hex_digit(c[7:4]), 1'b0);
			emit_byte(hex_digit(c[3:0]), 1'b0);
		end else if (c < 8'h80) begin
			emit_byte(c, 1'b0);
		end else if (c >= 8'hc2 && c <= 8'hf4) begin
			held[0] = c;
			held_n = 2'd1;
			seq_len = (c <= 8'hdf) ? 3'd2 : ((c <= 8'hef) ? 3'd3 : 3'd4);
		end else begin
			emit_replacement();
		end
	endtask

	task automatic predict_beat(input logic [7:0] c, input logic fin);
		beat_bytes = 0;
		if (!str_open) begin
			emit_byte(jse_pkg::CH_QUOTE, 1'b0);
			str_open = 1'b1;
		end
		if (fin) begin
			flush_held();
			emit_byte(jse_pkg::CH_QUOTE, 1'b1);
			str_open = 1'b0;
		end else if (held_n != 2'd0) begin
			if (cont_ok(held[0], held_n, c)) begin
				if (int'(held_n) + 1 >= int'(seq_len)) begin
					for (int i = 0; i < int'(held_n); i++) emit_byte(held[i], 1'b0);
					emit_byte(c, 1'b0);
					held_n = 2'd0;
					seq_len = 3'd0;
				end else begin
					held[held_n] = c;
					held_n++;
				end
			end else begin
				flush_held();
				escape_fresh(c);
			end
		end else begin
			escape_fresh(c);
		end
		if (beat_bytes > 0) expected_text[expected_text.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_byte_t want;
		if (!arst_n) begin
			expected_text.delete();
			str_open = 1'b0;
			held_n = 2'd0;
			seq_len = 3'd0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %b close %b",
						out_byte, run_last, closing_quote));
				end else begin
					want = expected_text.pop_front();
					if (out_byte !== want.value || run_last !== want.last ||
						closing_quote !== want.close) begin
						report_mismatch($sformatf(
							"got %02h/%b/%b want %02h/%b/%b (byte/last/close)",
							out_byte, run_last, closing_quote,
							want.value, want.last, want.close));
					end
				end
			end
			if (in_valid && in_ready) predict_beat(data_byte, string_end);
			pending <= expected_text.size();
		end
	end

endmodule

### verif/tb_top.sv
// tb_top: drives directed and random byte streams into the JSON string escaper
// with random idling on both channels; jse_text_checker does the checking.
// Depends on jse_pkg, json_string_escaper_utf8_sanitize_top and jse_text_checker.
module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BEATS = 145;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       string_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       closing_quote;
	logic       quiet = 1'b0;
	int         mismatches;
	int         pending;
	int         beats_sent = 0;
	int         stall_left = 0;
	int         idle_cycles = 0;

	json_string_escaper_utf8_sanitize_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.string_end(string_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.run_last(run_last),
		.closing_quote(closing_quote)
	);

	jse_text_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.string_end(string_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.run_last(run_last),
		.closing_quote(closing_quote),
		.mismatches(mismatches),
		.pending(pending)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// valid stays high across back-to-back beats
	task automatic send_beat(input logic [7:0] b, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		string_end <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	// lead byte plus conts continuation bytes, all in range
	task automatic send_utf8(input int len, input int conts);
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		case (len)
			2: lead = 8'($urandom_range(8'hc2, 8'hdf));
			3: begin
				case ($urandom_range(0, 3))
					0: lead = jse_pkg::LEAD_E0;
					1: lead = jse_pkg::LEAD_ED;
					default: lead = 8'($urandom_range(8'he1, 8'hef));
				endcase
			end
			default: begin
				case ($urandom_range(0, 3))
					0: lead = jse_pkg::LEAD_F0;
					1: lead = jse_pkg::LEAD_F4;
					default: lead = 8'($urandom_range(8'hf1, 8'hf3));
				endcase
			end
		endcase
		send_beat(lead, 1'b0);
		for (int i = 1; i <= conts; i++) begin
			lo = 8'h80;
			hi = 8'hbf;
			if (i == 1) begin
				if (lead == jse_pkg::LEAD_E0) lo = 8'ha0;
				else if (lead == jse_pkg::LEAD_ED) hi = 8'h9f;
				else if (lead == jse_pkg::LEAD_F0) lo = 8'h90;
				else if (lead == jse_pkg::LEAD_F4) hi = 8'h8f;
			end
			send_beat(8'($urandom_range(lo, hi)), 1'b0);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 99) < 25) begin
			out_ready <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) :
				$urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int start;
		int len;
		int kind;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// closing a string that was never opened
		send_beat(8'h00, 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat(8'h1f, 1'b0);
		send_beat(jse_pkg::CH_QUOTE, 1'b0);
		send_beat(jse_pkg::CH_BSLASH, 1'b0);
		send_beat(jse_pkg::CH_LF, 1'b0);
		send_beat(jse_pkg::CH_CR, 1'b0);
		send_beat(jse_pkg::CH_TAB, 1'b0);
		send_beat(8'h7f, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'hff, 1'b0);
		send_beat(jse_pkg::LEAD_E0, 1'b0);
		send_beat(8'ha0, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(jse_pkg::LEAD_F4, 1'b0);
		send_beat(8'h8f, 1'b0);
		send_beat(8'hbf, 1'b0);
		send_beat(8'hbf, 1'b0);
		// broken: E0 followed by an out-of-range continuation
		send_beat(jse_pkg::LEAD_E0, 1'b0);
		send_beat(8'h9f, 1'b0);
		send_beat(jse_pkg::LEAD_F0, 1'b0);
		send_beat(8'h90, 1'b0);
		send_beat(8'h41, 1'b0);
		// truncated at end of string
		send_beat(8'he1, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'h00, 1'b1);

		start = beats_sent;
		while (beats_sent - start < RANDOM_BEATS) begin
			if ($urandom_range(0, 15) == 0) quiet <= ($urandom_range(0, 2) == 0);
			kind = $urandom_range(0, 99);
			len = $urandom_range(2, 4);
			if (kind < 30) begin
				send_beat(8'($urandom_range(8'h20, 8'h7f)), 1'b0);
			end else if (kind < 38) begin
				send_beat(8'($urandom_range(8'h00, 8'h1f)), 1'b0);
			end else if (kind < 42) begin
				send_beat(($urandom_range(0, 1) == 0) ? jse_pkg::CH_QUOTE :
					jse_pkg::CH_BSLASH, 1'b0);
			end else if (kind < 67) begin
				send_utf8(len, len - 1);
			end else if (kind < 77) begin
				send_utf8(len, $urandom_range(0, len - 2));
				send_beat(8'($urandom()), 1'b0);
			end else if (kind < 89) begin
				send_beat(8'($urandom()), 1'b0);
			end else if (kind < 94) begin
				send_utf8(len, $urandom_range(0, len - 2));
				send_beat(8'($urandom()), 1'b1);
			end else begin
				send_beat(8'($urandom()), 1'b1);
			end
		end
		send_beat(8'($urandom()), 1'b1);
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
